[hdl/lsc_pkg.sv]
package lsc_pkg;

   localparam int unsigned TICK_W  = 8;
   localparam int unsigned DOT_W   = 9;
   localparam int unsigned LINE_W  = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned STAT_EN_W  = 4;

   localparam logic [DOT_W-1:0]  LINE_CYCLES   = DOT_W'(456);
   localparam logic [LINE_W-1:0] TOTAL_LINES   = LINE_W'(154);
   localparam logic [LINE_W-1:0] VISIBLE_LINES = LINE_W'(144);
   localparam logic [DOT_W-1:0]  OAM_DOTS      = DOT_W'(80);
   localparam logic [DOT_W-1:0]  DRAW_END_DOTS = DOT_W'(80 + 172);

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DISPLAY_ENABLE = 2'd0,
      REG_LINE_COMPARE   = 2'd1,
      REG_STATUS_ENABLES = 2'd2
   } csr_index_type;

   // Status enable bit positions
   localparam int unsigned STAT_HBLANK_BIT = 0;
   localparam int unsigned STAT_VBLANK_BIT = 1;
   localparam int unsigned STAT_OAM_BIT    = 2;
   localparam int unsigned STAT_MATCH_BIT  = 3;

endpackage

[hdl/lcd_scanline_timing_controller.sv]
// LCD scanline timing controller.
//
// Input channel (req_*): each transaction carries tick_cycles, the machine
// cycles elapsed since the previous transaction. The block advances a dot
// counter within a 456-dot line, steps the line number 0..153 and derives
// the mode (OAM search, drawing, HBlank, VBlank).
// Result channel (rsp_*): exactly one transaction per input transaction with
// the new line, mode, LY=LYC coincidence, a VBlank pulse on entering line 144
// and a level-style status request gated by the enable bits.
// Configuration (csr_*): single-cycle writes of display enable, line compare
// and status enables; an index past the last register is ignored.
// The result is valid the cycle after the input is accepted.
// Throughput: one transaction per clock unless stalled, set by the single
// timing state register update, which the next transaction reads at once.
// Stalls: the result register holds while rsp_ready is low; req_ready then
// drops until the held result is taken, so nothing is lost or repeated.
// Reset: counter and line clear, mode returns to OAM search, display enable
// sets, compare and enables clear, and no result is pending.
module lcd_scanline_timing_controller
   import lsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TICK_W-1:0]     req_tick_cycles,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LINE_W-1:0]     rsp_line_number,
   output logic [1:0]            rsp_mode,
   output logic                  rsp_coincidence,
   output logic                  rsp_vblank_request,
   output logic                  rsp_status_request,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // Configuration registers
   logic                 display_enable_ff, display_enable_in;
   logic [LINE_W-1:0]    line_compare_ff, line_compare_in;
   logic [STAT_EN_W-1:0] stat_en_ff, stat_en_in;

   // Timing state
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [LINE_W-1:0] line_ff, line_in;
   mode_type          mode_ff, mode_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0] rsp_line_ff, rsp_line_in;
   mode_type          rsp_mode_ff, rsp_mode_in;
   logic              rsp_match_ff, rsp_match_in;
   logic              rsp_vblank_ff, rsp_vblank_in;
   logic              rsp_stat_ff, rsp_stat_in;

   logic              req_fire;
   logic [DOT_W:0]    dot_sum;
   logic              line_wrap;
   logic [DOT_W-1:0]  dot_next;
   logic [LINE_W:0]   line_inc;
   logic [LINE_W-1:0] line_next;
   mode_type          mode_next;
   logic              match_next;
   logic              stat_next;

   // Accept while the result slot is empty or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // CSR decode
   always_comb begin
      display_enable_in = display_enable_ff;
      line_compare_in   = line_compare_ff;
      stat_en_in        = stat_en_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_DISPLAY_ENABLE: display_enable_in = csr_write_data[0];
            REG_LINE_COMPARE:   line_compare_in   = csr_write_data[LINE_W-1:0];
            REG_STATUS_ENABLES: stat_en_in        = csr_write_data[STAT_EN_W-1:0];
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // Advance the dot counter; it wraps at most once because a tick is below
   // one line's worth of dots.
   always_comb begin
      dot_sum   = {1'b0, dot_ff} + (DOT_W+1)'(req_tick_cycles);
      line_wrap = dot_sum >= {1'b0, LINE_CYCLES};
      dot_next  = line_wrap ? DOT_W'(dot_sum - {1'b0, LINE_CYCLES}) : dot_sum[DOT_W-1:0];
      line_inc  = {1'b0, line_ff} + (LINE_W+1)'(1);
      if (!line_wrap) begin
         line_next = line_ff;
      end else if (line_inc >= {1'b0, TOTAL_LINES}) begin
         line_next = '0;
      end else begin
         line_next = line_inc[LINE_W-1:0];
      end

      if (line_next >= VISIBLE_LINES) begin
         mode_next = MODE_VBLANK;
      end else if (dot_next < OAM_DOTS) begin
         mode_next = MODE_OAM;
      end else if (dot_next < DRAW_END_DOTS) begin
         mode_next = MODE_DRAW;
      end else begin
         mode_next = MODE_HBLANK;
      end

      match_next = line_next == line_compare_ff;
      stat_next  = (stat_en_ff[STAT_HBLANK_BIT] && mode_next == MODE_HBLANK)
                || (stat_en_ff[STAT_VBLANK_BIT] && mode_next == MODE_VBLANK)
                || (stat_en_ff[STAT_OAM_BIT]    && mode_next == MODE_OAM)
                || (stat_en_ff[STAT_MATCH_BIT]  && match_next);
   end

   // State and result next values
   always_comb begin
      dot_in        = dot_ff;
      line_in       = line_ff;
      mode_in       = mode_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_vblank_in = rsp_vblank_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (!display_enable_ff) begin
            // Display off: clear counter and line, hold the mode, no flags
            dot_in        = '0;
            line_in       = '0;
            rsp_line_in   = '0;
            rsp_mode_in   = mode_ff;
            rsp_match_in  = 1'b0;
            rsp_vblank_in = 1'b0;
            rsp_stat_in   = 1'b0;
         end else begin
            dot_in        = dot_next;
            line_in       = line_next;
            mode_in       = mode_next;
            rsp_line_in   = line_next;
            rsp_mode_in   = mode_next;
            rsp_match_in  = match_next;
            rsp_vblank_in = line_wrap && (line_next == VISIBLE_LINES);
            rsp_stat_in   = stat_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_enable_ff <= 1'b1;
         line_compare_ff   <= '0;
         stat_en_ff        <= '0;
         dot_ff            <= '0;
         line_ff           <= '0;
         mode_ff           <= MODE_OAM;
         rsp_valid_ff      <= 1'b0;
      end else begin
         display_enable_ff <= display_enable_in;
         line_compare_ff   <= line_compare_in;
         stat_en_ff        <= stat_en_in;
         dot_ff            <= dot_in;
         line_ff           <= line_in;
         mode_ff           <= mode_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload: no reset needed
   always_ff @(posedge clock) begin
      rsp_line_ff   <= rsp_line_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_vblank_ff <= rsp_vblank_in;
      rsp_stat_ff   <= rsp_stat_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_number    = rsp_line_ff;
   assign rsp_mode           = rsp_mode_ff;
   assign rsp_coincidence    = rsp_match_ff;
   assign rsp_vblank_request = rsp_vblank_ff;
   assign rsp_status_request = rsp_stat_ff;

endmodule

[hdl/lsc_checker.sv]
module lsc_checker
   import lsc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [LINE_W-1:0] rsp_line_number,
   input logic [1:0]        rsp_mode,
   input logic              rsp_vblank_request
);

   // Nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_number))
      else $error("stalled result changed");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number < TOTAL_LINES)
      else $error("line number out of range");

   a_vblank_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_request |->
         rsp_line_number == VISIBLE_LINES && rsp_mode == MODE_VBLANK)
      else $error("vblank pulse off the first vblank line");

   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_number >= VISIBLE_LINES |-> rsp_mode == MODE_VBLANK)
      else $error("mode not vblank on a vblank line");

endmodule

bind lcd_scanline_timing_controller lsc_checker u_lsc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_line_number    (rsp_line_number),
   .rsp_mode           (rsp_mode),
   .rsp_vblank_request (rsp_vblank_request)
);
